/* src/cbm_pkg.sv */
`timescale 1ns / 1ps
// cbm_pkg: shared types and constants for the cartridge bank mapper
// used by the interfaces, the controller, the datapath and the checker

package cbm_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int REQ_W     = 3;
  localparam int MADDR_W   = 19;
  localparam int CIRAM_W   = 11;
  localparam int PRG_CNT_W = 7;
  localparam int CHR_CNT_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int DIV_CNT_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_CPU_RD = 3'd0,
    REQ_CPU_WR = 3'd1,
    REQ_PPU_RD = 3'd2,
    REQ_PPU_WR = 3'd3,
    REQ_PPU_DOT = 3'd4,
    REQ_NT_REMAP = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_WRAM = 2'd1,
    MEM_PRG  = 2'd2,
    MEM_CHR  = 2'd3
  } mem_sel_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRES  = 2'd2;

  localparam logic [PRG_CNT_W-1:0] PRG_BANKS_RST = 7'd32;
  localparam logic [CHR_CNT_W-1:0] CHR_BANKS_RST = 9'd256;
  localparam logic [7:0]           PROTECT_RST   = 8'h80;

  // cpu register decode after masking with 0xe001
  localparam logic [ADDR_W-1:0] REG_MASK      = 16'hE001;
  localparam logic [ADDR_W-1:0] REG_BANK_SEL  = 16'h8000;
  localparam logic [ADDR_W-1:0] REG_BANK_DATA = 16'h8001;
  localparam logic [ADDR_W-1:0] REG_PROTECT   = 16'hA001;
  localparam logic [ADDR_W-1:0] REG_IRQ_LATCH = 16'hC000;
  localparam logic [ADDR_W-1:0] REG_IRQ_RELD  = 16'hC001;
  localparam logic [ADDR_W-1:0] REG_IRQ_DIS   = 16'hE000;
  localparam logic [ADDR_W-1:0] REG_IRQ_EN    = 16'hE001;

  localparam logic [3:0] A12_LOW_MIN = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic out_load;
  } cbm_cmd_t;

  typedef struct packed {
    logic need_div;
  } cbm_sts_t;

endpackage

/* src/cbm_in_if.sv */
`timescale 1ns / 1ps
// cbm_in_if: request channel carrying bus accesses into the mapper
// depends on cbm_pkg

interface cbm_in_if
  import cbm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wr_data;

  modport source (output valid, req_type, addr, wr_data, input ready);
  modport sink   (input valid, req_type, addr, wr_data, output ready);
endinterface

/* src/cbm_out_if.sv */
`timescale 1ns / 1ps
// cbm_out_if: result channel carrying decoded memory accesses
// depends on cbm_pkg

interface cbm_out_if
  import cbm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               handled;
  logic [1:0]         mem_select;
  logic [MADDR_W-1:0] mem_addr;
  logic               write_enable;
  logic [DATA_W-1:0]  write_data;
  logic [CIRAM_W-1:0] ciram_addr;
  logic               irq_level;

  modport source (output valid, handled, mem_select, mem_addr, write_enable, write_data,
                  ciram_addr, irq_level, input ready);
  modport sink   (input valid, handled, mem_select, mem_addr, write_enable, write_data,
                  ciram_addr, irq_level, output ready);
endinterface

/* src/cbm_ctrl.sv */
`timescale 1ns / 1ps
// cbm_ctrl: request sequencer for the mapper
// depends on cbm_pkg; drives cbm_dp through cbm_cmd_t

module cbm_ctrl
  import cbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cbm_sts_t sts,
  output cbm_cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cmd.div_step ? cnt_r + 1'b1 : '0;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/cbm_dp.sv */
`timescale 1ns / 1ps
// cbm_dp: mapper registers, irq counter, address decode, bank modulo unit
// and result register; depends on cbm_pkg, sequenced by cbm_ctrl

module cbm_dp
  import cbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [ADDR_W-1:0]    in_addr,
  input  logic [DATA_W-1:0]    in_wr_data,
  input  cbm_cmd_t             cmd,
  output cbm_sts_t             sts,
  output logic                 out_handled,
  output logic [1:0]           out_mem_select,
  output logic [MADDR_W-1:0]   out_mem_addr,
  output logic                 out_write_enable,
  output logic [DATA_W-1:0]    out_write_data,
  output logic [CIRAM_W-1:0]   out_ciram_addr,
  output logic                 out_irq_level
);

  // configuration
  logic [PRG_CNT_W-1:0] prg_n_r;
  logic [CHR_CNT_W-1:0] chr_n_r;
  logic                 ram_pres_r;

  // mapper state
  logic [7:0] bank_sel_r, bank_sel_nxt;
  logic [7:0] bank_reg_r [8];
  logic [7:0] bank_reg_nxt [8];
  logic [7:0] protect_r, protect_nxt;
  logic [7:0] rld_val_r, rld_val_nxt;
  logic [7:0] irq_cnt_r, irq_cnt_nxt;
  logic       irq_en_r, irq_en_nxt;
  logic       irq_pend_r, irq_pend_nxt;
  logic       prev_a12_r, prev_a12_nxt;
  logic [3:0] low_run_r, low_run_nxt;
  logic       irq_r, irq_nxt;

  // decode of the current request
  logic               p_handled, p_we, p_div;
  mem_sel_t           p_sel;
  logic [12:0]        p_off;
  logic [DATA_W-1:0]  p_wd;
  logic [CIRAM_W-1:0] p_ci;
  logic [7:0]         p_dvd;
  logic [CHR_CNT_W-1:0] p_dvs;
  logic [ADDR_W-1:0]  reg_addr;
  logic [7:0]         prg_nm2, prg_nm1, prg_bank;
  logic [12:0]        chr_a;
  logic [7:0]         chr_bank;
  logic [2:0]         chr_idx;

  // held request and modulo unit
  logic                 pnd_handled_r, pnd_we_r, pnd_irq_r;
  mem_sel_t             pnd_sel_r;
  logic [12:0]          pnd_off_r;
  logic [DATA_W-1:0]    pnd_wd_r;
  logic [CIRAM_W-1:0]   pnd_ci_r;
  logic [7:0]           dvd_r;
  logic [CHR_CNT_W-1:0] dvs_r;
  logic [CHR_CNT_W-1:0] rem_r, rem_nxt;
  logic [CHR_CNT_W:0]   rem_sh;

  // result register
  logic               res_handled_r, res_we_r, res_irq_r;
  logic [1:0]         res_sel_r;
  logic [MADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [DATA_W-1:0]  res_wd_r;
  logic [CIRAM_W-1:0] res_ci_r;

  assign sts.need_div = p_div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_n_r    <= PRG_BANKS_RST;
      chr_n_r    <= CHR_BANKS_RST;
      ram_pres_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_BANKS: prg_n_r    <= cfg_data[PRG_CNT_W-1:0];
        CFG_CHR_BANKS: chr_n_r    <= cfg_data[CHR_CNT_W-1:0];
        CFG_RAM_PRES:  ram_pres_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // chr bank lookup, shared by pattern accesses and nametable remap
  always_comb begin
    chr_a = (in_req_type == REQ_NT_REMAP) ? {1'b0, in_addr[11:0]} : in_addr[12:0];
    chr_idx = 3'd2 + {1'b0, chr_a[11:10]};
    if (!bank_sel_r[7]) begin
      if (chr_a[12:11] == 2'b00) begin
        chr_bank = {bank_reg_r[0][7:1], chr_a[10]};
      end else if (!chr_a[12]) begin
        chr_bank = {bank_reg_r[1][7:1], chr_a[10]};
      end else begin
        chr_bank = bank_reg_r[chr_idx];
      end
    end else begin
      if (!chr_a[12]) begin
        chr_bank = bank_reg_r[chr_idx];
      end else if (!chr_a[11]) begin
        chr_bank = {bank_reg_r[0][7:1], chr_a[10]};
      end else begin
        chr_bank = {bank_reg_r[1][7:1], chr_a[10]};
      end
    end
  end

  // prg bank lookup; a count of one wraps n-2 to 255, which still reduces to 0
  always_comb begin
    prg_nm2 = {1'b0, prg_n_r} - 8'd2;
    prg_nm1 = {1'b0, prg_n_r} - 8'd1;
    case (in_addr[14:13])
      2'b00:   prg_bank = bank_sel_r[6] ? prg_nm2 : bank_reg_r[6];
      2'b01:   prg_bank = bank_reg_r[7];
      2'b10:   prg_bank = bank_sel_r[6] ? bank_reg_r[6] : prg_nm2;
      default: prg_bank = prg_nm1;
    endcase
  end

  assign reg_addr = in_addr & REG_MASK;

  always_comb begin
    p_handled = 1'b0;
    p_sel     = MEM_NONE;
    p_off     = '0;
    p_we      = 1'b0;
    p_wd      = '0;
    p_ci      = '0;
    p_div     = 1'b0;
    p_dvd     = '0;
    p_dvs     = '0;

    bank_sel_nxt   = bank_sel_r;
    bank_reg_nxt   = bank_reg_r;
    protect_nxt    = protect_r;
    rld_val_nxt    = rld_val_r;
    irq_cnt_nxt    = irq_cnt_r;
    irq_en_nxt     = irq_en_r;
    irq_pend_nxt   = irq_pend_r;
    prev_a12_nxt   = prev_a12_r;
    low_run_nxt    = low_run_r;
    irq_nxt        = irq_r;

    case (in_req_type)
      REQ_CPU_RD: begin
        if (in_addr[15:13] == 3'b011) begin
          p_handled = 1'b1;
          if (protect_r[7] && ram_pres_r) begin
            p_sel = MEM_WRAM;
            p_off = in_addr[12:0];
          end
        end else if (in_addr[15]) begin
          p_handled = 1'b1;
          if (prg_n_r != '0) begin
            p_sel = MEM_PRG;
            p_off = in_addr[12:0];
            p_div = 1'b1;
            p_dvd = prg_bank;
            p_dvs = {{(CHR_CNT_W-PRG_CNT_W){1'b0}}, prg_n_r};
          end
        end
      end
      REQ_CPU_WR: begin
        if (in_addr[15:13] == 3'b011) begin
          p_handled = 1'b1;
          if (protect_r[7:6] == 2'b10 && ram_pres_r) begin
            p_sel = MEM_WRAM;
            p_off = in_addr[12:0];
            p_we  = 1'b1;
            p_wd  = in_wr_data;
          end
        end else if (in_addr[15]) begin
          p_handled = 1'b1;
          case (reg_addr)
            REG_BANK_SEL:  bank_sel_nxt = in_wr_data;
            REG_BANK_DATA: bank_reg_nxt[bank_sel_r[2:0]] = in_wr_data;
            REG_PROTECT:   protect_nxt = in_wr_data;
            REG_IRQ_LATCH: rld_val_nxt = in_wr_data;
            REG_IRQ_RELD:  irq_pend_nxt = 1'b1;
            REG_IRQ_DIS: begin
              irq_en_nxt = 1'b0;
              irq_nxt    = 1'b0;
            end
            REG_IRQ_EN:    irq_en_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      REQ_PPU_RD, REQ_PPU_WR: begin
        if (in_addr[15:13] == 3'b000 && chr_n_r != '0) begin
          p_handled = 1'b1;
          p_sel     = MEM_CHR;
          p_off     = {3'b000, in_addr[9:0]};
          p_div     = 1'b1;
          p_dvd     = chr_bank;
          p_dvs     = chr_n_r;
          if (in_req_type == REQ_PPU_WR) begin
            p_we = 1'b1;
            p_wd = in_wr_data;
          end
        end
      end
      REQ_PPU_DOT: begin
        if (!in_addr[12]) begin
          if (low_run_r < A12_LOW_MIN) begin
            low_run_nxt = low_run_r + 4'd1;
          end
        end else begin
          // filtered rising edge of a12 clocks the scanline counter
          if (!prev_a12_r && low_run_r >= A12_LOW_MIN) begin
            if (irq_cnt_r == 8'd0 || irq_pend_r) begin
              irq_cnt_nxt  = rld_val_r;
              irq_pend_nxt = 1'b0;
            end else begin
              irq_cnt_nxt = irq_cnt_r - 8'd1;
            end
            if (irq_cnt_nxt == 8'd0 && irq_en_r) begin
              irq_nxt = 1'b1;
            end
          end
          low_run_nxt = '0;
        end
        prev_a12_nxt = in_addr[12];
      end
      REQ_NT_REMAP: begin
        p_handled = 1'b1;
        p_ci      = {chr_bank[7], in_addr[9:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r   <= '0;
      bank_reg_r   <= '{default: '0};
      protect_r    <= PROTECT_RST;
      rld_val_r    <= '0;
      irq_cnt_r    <= '0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      prev_a12_r   <= 1'b0;
      low_run_r    <= '0;
      irq_r        <= 1'b0;
    end else if (cmd.accept) begin
      bank_sel_r   <= bank_sel_nxt;
      bank_reg_r   <= bank_reg_nxt;
      protect_r    <= protect_nxt;
      rld_val_r    <= rld_val_nxt;
      irq_cnt_r    <= irq_cnt_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_pend_r   <= irq_pend_nxt;
      prev_a12_r   <= prev_a12_nxt;
      low_run_r    <= low_run_nxt;
      irq_r        <= irq_nxt;
    end
  end

  // restoring remainder, one dividend bit per step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[7]};
    rem_nxt = rem_sh[CHR_CNT_W-1:0];
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = CHR_CNT_W'(rem_sh - {1'b0, dvs_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pnd_handled_r <= p_handled;
      pnd_sel_r     <= p_sel;
      pnd_off_r     <= p_off;
      pnd_we_r      <= p_we;
      pnd_wd_r      <= p_wd;
      pnd_ci_r      <= p_ci;
      pnd_irq_r     <= irq_nxt;
      dvd_r         <= p_dvd;
      dvs_r         <= p_dvs;
      rem_r         <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[6:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    case (pnd_sel_r)
      MEM_WRAM: res_addr_nxt = {6'd0, pnd_off_r};
      MEM_PRG:  res_addr_nxt = {rem_r[5:0], pnd_off_r};
      MEM_CHR:  res_addr_nxt = {rem_r, pnd_off_r[9:0]};
      default:  res_addr_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_handled_r <= pnd_handled_r;
      res_sel_r     <= pnd_sel_r;
      res_addr_r    <= res_addr_nxt;
      res_we_r      <= pnd_we_r;
      res_wd_r      <= pnd_wd_r;
      res_ci_r      <= pnd_ci_r;
      res_irq_r     <= pnd_irq_r;
    end
  end

  assign out_handled      = res_handled_r;
  assign out_mem_select   = res_sel_r;
  assign out_mem_addr     = res_addr_r;
  assign out_write_enable = res_we_r;
  assign out_write_data   = res_wd_r;
  assign out_ciram_addr   = res_ci_r;
  assign out_irq_level    = res_irq_r;

endmodule

/* src/cartridge_bank_mapper_scanline_irq.sv */
`timescale 1ns / 1ps
// cartridge_bank_mapper_scanline_irq: top level of the bank mapper
// depends on cbm_pkg, cbm_in_if, cbm_out_if, cbm_ctrl, cbm_dp
//
//   port       dir   kind                  carries
//   in_req     in    valid/ready channel   req_type, addr, wr_data
//   out_res    out   valid/ready channel   handled .. irq_level
//   cfg_*      in    write-only port       bank counts, work ram present
//
// sequence: a request that selects prg rom or chr memory goes through accept,
// 8 steps of the bank modulo unit, result load; any other skips the steps
// a new request is taken while the previous result still waits at the output
// a stalled output holds the next result in the done state until it drains
// reset is synchronous, active low, and restores all mapper registers

module cartridge_bank_mapper_scanline_irq
  import cbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  cbm_in_if.sink               in_req,
  cbm_out_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cbm_cmd_t cmd;
  cbm_sts_t sts;

  cbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req.req_type),
    .in_addr          (in_req.addr),
    .in_wr_data       (in_req.wr_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_handled      (out_res.handled),
    .out_mem_select   (out_res.mem_select),
    .out_mem_addr     (out_res.mem_addr),
    .out_write_enable (out_res.write_enable),
    .out_write_data   (out_res.write_data),
    .out_ciram_addr   (out_res.ciram_addr),
    .out_irq_level    (out_res.irq_level)
  );

endmodule

/* src/cbm_checker.sv */
`timescale 1ns / 1ps
// cbm_sva: port-level assertions for the bank mapper result channel
// depends on cbm_pkg; bound to the top level below

module cbm_sva
  import cbm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_handled,
  input logic [1:0]         out_mem_select,
  input logic [MADDR_W-1:0] out_mem_addr,
  input logic               out_write_enable,
  input logic [CIRAM_W-1:0] out_ciram_addr
);

  // a result waiting for the sink stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mem_addr)
      && $stable(out_ciram_addr))
    else $error("result changed while stalled");

  a_unclaimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_handled |-> out_mem_select == MEM_NONE
      && !out_write_enable && out_ciram_addr == '0)
    else $error("unclaimed access selects memory");

  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |->
      out_mem_select == MEM_WRAM || out_mem_select == MEM_CHR)
    else $error("write to prg rom or no memory");

  a_no_sel_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_select == MEM_NONE |-> out_mem_addr == '0)
    else $error("address given with nothing selected");

  a_wram_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_select == MEM_WRAM |-> out_mem_addr[18:13] == '0)
    else $error("work ram address out of range");

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_sva u_cbm_sva (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_handled      (out_res.handled),
  .out_mem_select   (out_res.mem_select),
  .out_mem_addr     (out_res.mem_addr),
  .out_write_enable (out_res.write_enable),
  .out_ciram_addr   (out_res.ciram_addr)
);
